@@ src/adjtab_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package adjtab_pkg;

  localparam int OP_W     = 2;
  localparam int ID_W     = 10;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;
  localparam int LIMIT_W  = 11;
  localparam int SPN_W    = 5;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_MAX_SLOTS = 16;

  localparam logic [LIMIT_W-1:0] NODE_LIMIT_RST = '0;
  localparam logic [SPN_W-1:0]   SPN_RST        = 5'd4;

  localparam logic REG_NODE_LIMIT = 1'b0;
  localparam logic REG_SLOTS      = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_A_FULL = 2'd1,
    ST_B_FULL = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] node_limit;
    logic [SPN_W-1:0]   slots_per_node;
  } cfg_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_START,
    S_RD_B,
    S_CHK_B,
    S_WR_B,
    S_RD_WAIT,
    S_CLEAR,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

@@ src/adjtab_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface adjtab_req_if;
  import adjtab_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ID_W-1:0]   node_a;
  logic [ID_W-1:0]   node_b;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, operation, node_a, node_b, slot, input ready);
  modport sink   (input valid, operation, node_a, node_b, slot, output ready);
endinterface

`default_nettype wire

@@ src/adjtab_res_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface adjtab_res_if;
  import adjtab_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                entry_valid;
  logic [ID_W-1:0]     entry_value;
  logic [COUNT_W-1:0]  node_count;
  logic                error_seen;

  modport source (output valid, status, entry_valid, entry_value, node_count, error_seen,
                  input ready);
  modport sink   (input valid, status, entry_valid, entry_value, node_count, error_seen,
                  output ready);
endinterface

`default_nettype wire

@@ src/edge_list_to_adjacency_table.sv @@
// Adjacency table built from undirected edges.
// Requests arrive on req (valid/ready) carrying operation, node_a, node_b
// and slot; each request gives exactly one result on res (valid/ready).
// Operations: insert edge, read one neighbour slot, clear the table, no-op.
// Registers node_limit and slots_per_node sit on the APB port (0x0, 0x4).
// One request is worked at a time; req.ready is high only while idle.
// A read waits on the table read; a clear sweeps all fill counts; a
// range error or a no-op goes from S_START straight to S_DONE;
// req.ready rises with res.valid. The fill-count memory has one read
// port, so an insert reads node_a's count and node_b's count in turn,
// then writes the two table entries (one for a self-loop) one per cycle
// through one address unit; a full list ends the insert with no write.
// The result register frees the core: the next request is accepted while
// a result still waits on a stalled receiver; the core only waits at the
// end of the following request until the register is free.
// After reset the fill counts are swept to zero with req.ready low;
// configuration writes are taken during the sweep.
`timescale 1ns / 1ps
`default_nettype none

module edge_list_to_adjacency_table #(
  parameter int MAX_NODES = adjtab_pkg::DEF_MAX_NODES,
  parameter int MAX_SLOTS = adjtab_pkg::DEF_MAX_SLOTS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  adjtab_req_if.sink                         req,
  adjtab_res_if.source                       res,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [adjtab_pkg::APB_AW-1:0] paddr,
  input  wire logic [adjtab_pkg::APB_DW-1:0] pwdata,
  output logic      [adjtab_pkg::APB_DW-1:0] prdata,
  output logic                               pready
);
  import adjtab_pkg::*;

  localparam int NW     = $clog2(MAX_NODES);
  localparam int FW     = $clog2(MAX_SLOTS + 1);
  localparam int TDEPTH = MAX_NODES * MAX_SLOTS;
  localparam int TW     = $clog2(TDEPTH);
  localparam int CNTW   = $clog2(MAX_NODES + 1);
  localparam int BW     = (CNTW > COUNT_W) ? CNTW : COUNT_W;
  localparam int CAPW   = (FW > SPN_W) ? FW : SPN_W;
  localparam int SCW    = (FW > SLOT_W) ? FW : SLOT_W;

  cfg_t cfg;

  adjtab_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t state, state_next;

  op_t               op_q;
  logic [ID_W-1:0]   a_q, b_q;
  logic [SLOT_W-1:0] s_q;
  logic [FW-1:0]     fa_q;
  status_t           res_status;
  logic              res_ev;
  logic [ID_W-1:0]   res_val;
  logic [ID_W-1:0]   largest;
  logic              any_seen;
  logic              sticky;
  logic [NW-1:0]     sweep;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic                out_ev;
  logic [ID_W-1:0]     out_val;
  logic [COUNT_W-1:0]  out_count;
  logic                out_err;

  // fill counts and neighbour table
  logic [FW-1:0]   fill_mem [MAX_NODES];
  logic [FW-1:0]   fill_rdata, fill_wdata;
  logic [NW-1:0]   fill_raddr, fill_waddr;
  logic            fill_we;
  logic [ID_W-1:0] tab_mem [TDEPTH];
  logic [ID_W-1:0] tab_rdata, tab_wdata;
  logic [TW-1:0]   tab_addr;
  logic            tab_we;
  logic [NW-1:0]   tab_node;
  logic [SCW-1:0]  tab_slot;

  logic [BW-1:0]   lim_ext, lim_eff, bound, eff_count;
  logic            limit_set, ins_oor, rd_oor;
  logic [CAPW-1:0] spn_ext, cap;
  logic            full;
  logic [FW-1:0]   inc_out;
  logic [ID_W-1:0] id_max;
  logic            note_upd, self_loop, sweep_last, accept, out_load, ins_fail;

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    fill_rdata <= fill_mem[fill_raddr];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_addr] <= tab_wdata;
    end
    tab_rdata <= tab_mem[tab_addr];
  end

  // shared address unit
  assign tab_addr = TW'(TW'(tab_node) * TW'(MAX_SLOTS) + TW'(tab_slot));

  assign limit_set = (cfg.node_limit != '0);
  assign lim_ext   = BW'(cfg.node_limit);
  assign lim_eff   = (lim_ext > BW'(MAX_NODES)) ? BW'(MAX_NODES) : lim_ext;
  assign bound     = limit_set ? lim_eff : BW'(MAX_NODES);
  assign eff_count = limit_set ? lim_eff :
                     (any_seen ? BW'(largest) + BW'(1) : '0);
  assign ins_oor   = (BW'(a_q) >= bound) || (BW'(b_q) >= bound);
  assign rd_oor    = (BW'(a_q) >= eff_count);

  assign spn_ext   = CAPW'(cfg.slots_per_node);
  assign cap       = (spn_ext > CAPW'(MAX_SLOTS)) ? CAPW'(MAX_SLOTS) : spn_ext;

  // shared compare and increment
  assign full      = (CAPW'(fill_rdata) >= cap);
  assign inc_out   = ((state == S_CHK_B) ? fa_q : fill_rdata) + FW'(1);

  assign id_max     = (a_q > b_q) ? a_q : b_q;
  assign note_upd   = !any_seen || (id_max > largest);
  assign self_loop  = (a_q == b_q);
  assign sweep_last = (sweep == NW'(MAX_NODES - 1));
  assign accept     = (state == S_IDLE) && req.valid;
  assign out_load   = (state == S_DONE) && (!out_valid || res.ready);
  assign ins_fail   = (op_q == OP_INSERT) && (res_status != ST_OK);

  assign req.ready       = (state == S_IDLE);
  assign res.valid       = out_valid;
  assign res.status      = out_status;
  assign res.entry_valid = out_ev;
  assign res.entry_value = out_val;
  assign res.node_count  = out_count;
  assign res.error_seen  = out_err;

  always_comb begin
    state_next = state;
    fill_raddr = NW'(a_q);
    fill_waddr = NW'(a_q);
    fill_wdata = inc_out;
    fill_we    = 1'b0;
    tab_node   = NW'(a_q);
    tab_slot   = SCW'(s_q);
    tab_wdata  = b_q;
    tab_we     = 1'b0;
    unique case (state)
      S_INIT, S_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = sweep;
        fill_wdata = '0;
        if (sweep_last) begin
          state_next = (state == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        unique case (op_q)
          OP_INSERT: state_next = ins_oor ? S_DONE : S_RD_B;
          OP_READ:   state_next = rd_oor ? S_DONE : S_RD_WAIT;
          OP_CLEAR:  state_next = S_CLEAR;
          OP_NOP:    state_next = S_DONE;
        endcase
      end
      S_RD_B: begin
        fill_raddr = NW'(b_q);
        state_next = full ? S_DONE : S_CHK_B;
      end
      S_CHK_B: begin
        fill_raddr = NW'(b_q);
        if (full && !self_loop) begin
          state_next = S_DONE;
        end else begin
          fill_we    = 1'b1;
          tab_we     = 1'b1;
          tab_slot   = SCW'(fa_q);
          state_next = self_loop ? S_DONE : S_WR_B;
        end
      end
      S_WR_B: begin
        fill_raddr = NW'(b_q);
        fill_we    = 1'b1;
        fill_waddr = NW'(b_q);
        tab_we     = 1'b1;
        tab_node   = NW'(b_q);
        tab_slot   = SCW'(fill_rdata);
        tab_wdata  = a_q;
        state_next = S_DONE;
      end
      S_RD_WAIT: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || res.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (state == S_INIT || state == S_CLEAR) begin
      sweep <= sweep_last ? '0 : sweep + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= op_t'(req.operation);
      a_q  <= req.node_a;
      b_q  <= req.node_b;
      s_q  <= req.slot;
    end
    if (state == S_RD_B) begin
      fa_q <= fill_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= ST_OK;
      res_ev     <= 1'b0;
      res_val    <= '0;
    end else begin
      unique case (state)
        S_START: begin
          if ((op_q == OP_INSERT && ins_oor) || (op_q == OP_READ && rd_oor)) begin
            res_status <= ST_RANGE;
          end
        end
        S_RD_B: begin
          if (full) begin
            res_status <= ST_A_FULL;
          end
        end
        S_CHK_B: begin
          if (full && !self_loop) begin
            res_status <= ST_B_FULL;
          end
        end
        S_RD_WAIT: begin
          if (SCW'(s_q) < SCW'(fill_rdata)) begin
            res_ev  <= 1'b1;
            res_val <= tab_rdata;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      largest  <= '0;
      any_seen <= 1'b0;
      sticky   <= 1'b0;
    end else begin
      if (state == S_START && op_q == OP_INSERT && !ins_oor && !limit_set && note_upd) begin
        largest  <= id_max;
        any_seen <= 1'b1;
      end
      if (state == S_CLEAR && sweep_last) begin
        largest  <= '0;
        any_seen <= 1'b0;
        sticky   <= 1'b0;
      end
      if (out_load && ins_fail) begin
        sticky <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_ev     <= res_ev;
      out_val    <= res_val;
      out_count  <= COUNT_W'(eff_count);
      out_err    <= sticky || ins_fail;
    end
  end

endmodule

`default_nettype wire

@@ src/adjtab_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module adjtab_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [adjtab_pkg::APB_AW-1:0] paddr,
  input  wire logic [adjtab_pkg::APB_DW-1:0] pwdata,
  output logic      [adjtab_pkg::APB_DW-1:0] prdata,
  output logic                             pready,
  output adjtab_pkg::cfg_t                 cfg
);
  import adjtab_pkg::*;

  cfg_t cfg_regs;
  logic reg_sel;

  assign reg_sel = paddr[APB_AW-1];
  assign pready  = 1'b1;
  assign cfg     = cfg_regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.node_limit     <= NODE_LIMIT_RST;
      cfg_regs.slots_per_node <= SPN_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_NODE_LIMIT: cfg_regs.node_limit     <= pwdata[LIMIT_W-1:0];
        REG_SLOTS:      cfg_regs.slots_per_node <= pwdata[SPN_W-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (reg_sel)
        REG_NODE_LIMIT: prdata = APB_DW'(cfg_regs.node_limit);
        REG_SLOTS:      prdata = APB_DW'(cfg_regs.slots_per_node);
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/adjtab_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module adjtab_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            req_valid,
  input wire logic                            req_ready,
  input wire logic                            res_valid,
  input wire logic                            res_ready,
  input wire logic [adjtab_pkg::STATUS_W-1:0] res_status,
  input wire logic                            res_entry_valid,
  input wire logic [adjtab_pkg::ID_W-1:0]     res_entry_value,
  input wire logic [adjtab_pkg::COUNT_W-1:0]  res_node_count,
  input wire logic                            res_error_seen
);
  import adjtab_pkg::*;

  // table sweep holds requests off right after reset
  a_reset_busy: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request taken during reset sweep");

  // at most one request in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while another is in work");

  a_entry_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_entry_valid) |-> (res_status == ST_OK))
    else $error("valid entry with failing status");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> ($stable(res_status) && $stable(res_entry_valid) &&
      $stable(res_entry_value) && $stable(res_node_count) && $stable(res_error_seen)))
    else $error("result changed while stalled");

endmodule

bind edge_list_to_adjacency_table adjtab_checker u_adjtab_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_status      (res.status),
  .res_entry_valid (res.entry_valid),
  .res_entry_value (res.entry_value),
  .res_node_count  (res.node_count),
  .res_error_seen  (res.error_seen)
);

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import adjtab_pkg::*;

  typedef struct {
    op_t               op;
    logic [ID_W-1:0]   node_a;
    logic [ID_W-1:0]   node_b;
    logic [SLOT_W-1:0] slot;
  } adj_request_t;

  typedef struct {
    status_t            status;
    logic               entry_valid;
    logic [ID_W-1:0]    entry_value;
    logic [COUNT_W-1:0] node_count;
    logic               error_seen;
  } adj_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  adjtab_req_if req_ch ();
  adjtab_res_if res_ch ();

  edge_list_to_adjacency_table u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  adj_request_t pending_reqs[$];
  adj_result_t  expected_results[$];

  logic [ID_W-1:0]    nbr_mem  [DEF_MAX_NODES][DEF_MAX_SLOTS];
  logic [SPN_W-1:0]   fill_cnt [DEF_MAX_NODES];
  logic [COUNT_W-1:0] top_id;
  logic               top_seen;
  logic               sticky;
  logic [LIMIT_W-1:0] cfg_limit;
  logic [SPN_W-1:0]   cfg_slots;

  adj_request_t cur_req;
  int idle_left;
  int stall_left;
  bit calm;
  int n_errors;
  int n_checked;
  int n_rejected;
  int n_hits;
  int n_clears;
  int n_settings;

  always #5 clk = ~clk;

  function automatic logic [COUNT_W-1:0] node_count_now();
    if (cfg_limit != 0)
      return COUNT_W'((cfg_limit > DEF_MAX_NODES) ? DEF_MAX_NODES : cfg_limit);
    return top_seen ? top_id + COUNT_W'(1) : '0;
  endfunction

  function automatic void note_id(logic [ID_W-1:0] id);
    if (!top_seen || id > top_id) begin
      top_id = COUNT_W'(id);
      top_seen = 1'b1;
    end
  endfunction

  function automatic status_t insert_edge(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
    int unsigned bound;
    int unsigned cap;
    bound = (cfg_limit != 0) ? node_count_now() : DEF_MAX_NODES;
    if (a >= bound || b >= bound) return ST_RANGE;
    if (cfg_limit == 0) begin
      note_id(a);
      note_id(b);
    end
    cap = (cfg_slots > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS : cfg_slots;
    if (fill_cnt[a] >= cap) return ST_A_FULL;
    if (a != b && fill_cnt[b] >= cap) return ST_B_FULL;
    nbr_mem[a][fill_cnt[a]] = b;
    fill_cnt[a]++;
    if (a != b) begin
      nbr_mem[b][fill_cnt[b]] = a;
      fill_cnt[b]++;
    end
    return ST_OK;
  endfunction

  function automatic adj_result_t apply_request(adj_request_t rq);
    adj_result_t r;
    r.status = ST_OK;
    r.entry_valid = 1'b0;
    r.entry_value = '0;
    case (rq.op)
      OP_INSERT: begin
        r.status = insert_edge(rq.node_a, rq.node_b);
        if (r.status != ST_OK) begin
          sticky = 1'b1;
          n_rejected++;
        end
      end
      OP_READ: begin
        if (rq.node_a >= node_count_now()) begin
          r.status = ST_RANGE;
        end else if (rq.slot < fill_cnt[rq.node_a]) begin
          r.entry_valid = 1'b1;
          r.entry_value = nbr_mem[rq.node_a][rq.slot];
          n_hits++;
        end
      end
      OP_CLEAR: begin
        foreach (fill_cnt[i]) fill_cnt[i] = '0;
        top_id = '0;
        top_seen = 1'b0;
        sticky = 1'b0;
        n_clears++;
      end
      default: ;
    endcase
    r.node_count = node_count_now();
    r.error_seen = sticky;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    if (n_errors <= 40)
      $display("result %0d: %s got %0d expected %0d", n_checked, what, got, want);
  endtask

  function automatic int pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_stall();
    int unsigned r;
    if (calm) return -1;
    r = $urandom_range(0, 99);
    if (r < 70) return -1;
    if (r < 95) return $urandom_range(0, 2);
    return $urandom_range(10, 50);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      idle_left = 0;
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_results = {expected_results, apply_request(cur_req)};
        idle_left = pick_gap();
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (idle_left > 0) begin
          idle_left--;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          req_ch.operation <= cur_req.op;
          req_ch.node_a <= cur_req.node_a;
          req_ch.node_b <= cur_req.node_b;
          req_ch.slot <= cur_req.slot;
          req_ch.valid <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      res_ch.ready <= 1'b1;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request waiting, status", res_ch.status, 0);
        end else begin
          adj_result_t e;
          e = expected_results.pop_front();
          if (res_ch.status !== e.status)
            report_mismatch("status", res_ch.status, e.status);
          if (res_ch.entry_valid !== e.entry_valid)
            report_mismatch("entry_valid", res_ch.entry_valid, e.entry_valid);
          if (res_ch.entry_value !== e.entry_value)
            report_mismatch("entry_value", res_ch.entry_value, e.entry_value);
          if (res_ch.node_count !== e.node_count)
            report_mismatch("node_count", res_ch.node_count, e.node_count);
          if (res_ch.error_seen !== e.error_seen)
            report_mismatch("error_seen", res_ch.error_seen, e.error_seen);
        end
        n_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        stall_left = pick_stall();
        res_ch.ready <= (stall_left < 0);
        if (stall_left < 0) stall_left = 0;
      end
    end
  end

  task automatic apb_write(input logic reg_idx, input logic [APB_DW-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [APB_DW-1:0] limit, input logic [APB_DW-1:0] slots);
    apb_write(REG_NODE_LIMIT, limit);
    apb_write(REG_SLOTS, slots);
    cfg_limit = limit[LIMIT_W-1:0];
    cfg_slots = slots[SPN_W-1:0];
    n_settings++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_ch.valid || expected_results.size() != 0);
    repeat (16) @(negedge clk);
  endtask

  task automatic add(op_t op, int a, int b, int s);
    adj_request_t rq;
    rq.op = op;
    rq.node_a = ID_W'(a);
    rq.node_b = ID_W'(b);
    rq.slot = SLOT_W'(s);
    pending_reqs = {pending_reqs, rq};
  endtask

  function automatic adj_request_t random_request(int unsigned span, int unsigned slot_span);
    adj_request_t rq;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 48) rq.op = OP_INSERT;
    else if (r < 94) rq.op = OP_READ;
    else if (r < 97) rq.op = OP_NOP;
    else rq.op = OP_CLEAR;
    rq.node_a = ID_W'($urandom_range(0, span));
    rq.node_b = ID_W'($urandom_range(0, span));
    if ($urandom_range(0, 15) == 0) rq.node_a = ID_W'($urandom_range(0, DEF_MAX_NODES - 1));
    if ($urandom_range(0, 15) == 0) rq.node_b = ID_W'($urandom_range(0, DEF_MAX_NODES - 1));
    if ($urandom_range(0, 9) == 0) rq.node_b = rq.node_a;
    rq.slot = ($urandom_range(0, 4) == 0) ? SLOT_W'($urandom_range(0, DEF_MAX_SLOTS - 1))
                                          : SLOT_W'($urandom_range(0, slot_span));
    return rq;
  endfunction

  int unsigned ph_limit [7] = '{0, 16, 1024, 2047, 1, 0, 300};
  int unsigned ph_slots [7] = '{4, 16, 1, 31, 2, 0, 7};
  int unsigned ph_span  [7] = '{7, 17, 1023, 12, 1, 9, 310};
  int unsigned ph_items [7] = '{260, 260, 230, 230, 150, 120, 300};

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_NOP;
    req_ch.node_a = '0;
    req_ch.node_b = '0;
    req_ch.slot = '0;
    res_ch.ready = 1'b1;
    foreach (fill_cnt[i]) fill_cnt[i] = '0;
    foreach (nbr_mem[i, j]) nbr_mem[i][j] = '0;
    top_id = '0;
    top_seen = 1'b0;
    sticky = 1'b0;
    cfg_limit = NODE_LIMIT_RST;
    cfg_slots = SPN_RST;
    calm = 1'b0;
    n_errors = 0;
    n_checked = 0;
    n_rejected = 0;
    n_hits = 0;
    n_clears = 0;
    n_settings = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset defaults: derived count, four slots
    add(OP_READ, 0, 0, 0);
    add(OP_NOP, 1023, 1023, 15);
    add(OP_INSERT, 0, 1023, 0);
    add(OP_INSERT, 5, 5, 0);
    add(OP_READ, 5, 0, 0);
    add(OP_READ, 5, 0, 1);
    add(OP_READ, 1023, 0, 0);
    add(OP_INSERT, 0, 1, 0);
    add(OP_INSERT, 0, 1, 0);
    add(OP_INSERT, 0, 1, 0);
    add(OP_INSERT, 0, 2, 0);
    add(OP_INSERT, 2, 0, 0);
    add(OP_READ, 0, 0, 3);
    add(OP_READ, 0, 0, 15);
    add(OP_CLEAR, 0, 0, 0);
    add(OP_INSERT, 1023, 1023, 0);
    wait_drained();

    set_config(10, 1);
    add(OP_INSERT, 3, 10, 0);
    add(OP_INSERT, 9, 0, 0);
    add(OP_INSERT, 9, 4, 0);
    add(OP_READ, 10, 0, 0);
    add(OP_READ, 9, 0, 0);
    wait_drained();

    // zero capacity; lists already filled still read back
    set_config(2047, 0);
    add(OP_INSERT, 1, 2, 0);
    add(OP_READ, 9, 0, 0);
    wait_drained();

    set_config(0, 31);
    add(OP_INSERT, 1023, 0, 0);
    add(OP_READ, 0, 0, 1);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      set_config(ph_limit[p], ph_slots[p]);
      calm = (p == 2);
      for (int i = 0; i < ph_items[p]; i++) begin
        pending_reqs = {pending_reqs,
                        random_request(ph_span[p], ph_slots[p] > 15 ? 15 : ph_slots[p])};
        if (p == 6 && i == ph_items[p] / 2) begin
          // sender holds off until every result is back
          wait_drained();
        end
      end
      wait_drained();
    end

    $display("%0d results checked across %0d register settings: %0d filled-slot reads,",
             n_checked, n_settings, n_hits);
    $display("%0d rejected inserts, %0d clears", n_rejected, n_clears);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ edge_list_to_adjacency_table.f @@
src/adjtab_pkg.sv
src/adjtab_req_if.sv
src/adjtab_res_if.sv
src/adjtab_cfg.sv
src/edge_list_to_adjacency_table.sv
src/adjtab_checker.sv
test/tb.sv
